/* design/assert_macros.svh */
// Assertion macros for the design files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Implication checked at every rising clock edge outside reset.
`define SPS_ASSERT(lbl, prop) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("assertion failed");
// Condition that must never be true outside reset.
`define SPS_NEVER(lbl, cond) \
   lbl: assert property (@(posedge clock) disable iff (reset) !(cond)) \
      else $error("forbidden condition seen");
`else
`define SPS_ASSERT(lbl, prop)
`define SPS_NEVER(lbl, cond)
`endif
`endif

/* design/sps_pkg.sv */
// Types, codes and coil tables of the stepper phase sequencer.
package sps_pkg;

   typedef logic [1:0]        opcode_type;
   typedef logic [1:0]        mode_type;
   typedef logic [31:0]       count_type;
   typedef logic [19:0]       interval_type;
   typedef logic [7:0]        speed_type;
   typedef logic [3:0]        coil_type;
   typedef logic signed [4:0] phase_type;

   localparam int CsrIdxW = 1;
   typedef logic [CsrIdxW-1:0] csr_index_type;

   localparam csr_index_type CSR_STEP_MODE     = 1'd0;
   localparam csr_index_type CSR_BASE_INTERVAL = 1'd1;

   localparam opcode_type OP_TICK  = 2'd0;
   localparam opcode_type OP_START = 2'd1;
   localparam opcode_type OP_STOP  = 2'd2;

   localparam mode_type MODE_OFF    = 2'd0;
   localparam mode_type MODE_SINGLE = 2'd1;
   localparam mode_type MODE_DOUBLE = 2'd2;
   localparam mode_type MODE_HALF   = 2'd3;

   localparam mode_type     MODE_RESET     = MODE_SINGLE;
   localparam interval_type INTERVAL_RESET = 20'd293;

   localparam int DivSteps = $bits(interval_type);
   localparam int DivCntW  = $clog2(DivSteps);

   // Coil pattern for a phase in a mode; keeps the old pattern when the
   // phase has no entry in that mode's table.
   function automatic coil_type phase_pattern(mode_type mode, phase_type ph,
                                              coil_type old);
      coil_type p;
      p = old;
      if (ph >= 0) begin
         case (mode)
            MODE_SINGLE: begin
               case (ph)
                  5'sd0:   p = 4'h1;
                  5'sd1:   p = 4'h2;
                  5'sd2:   p = 4'h4;
                  5'sd3:   p = 4'h8;
                  default: p = old;
               endcase
            end
            MODE_DOUBLE: begin
               case (ph)
                  5'sd0:   p = 4'h9;
                  5'sd1:   p = 4'h3;
                  5'sd2:   p = 4'h6;
                  5'sd3:   p = 4'hC;
                  default: p = old;
               endcase
            end
            MODE_HALF: begin
               case (ph)
                  5'sd0:   p = 4'h9;
                  5'sd1:   p = 4'h1;
                  5'sd2:   p = 4'h3;
                  5'sd3:   p = 4'h2;
                  5'sd4:   p = 4'h6;
                  5'sd5:   p = 4'h4;
                  5'sd6:   p = 4'hC;
                  5'sd7:   p = 4'h8;
                  default: p = old;
               endcase
            end
            default: p = old;
         endcase
      end
      return p;
   endfunction

endpackage

/* design/stepper_phase_sequencer.sv */
// Stepper phase sequencer: command decode, restoring divider, coil drive.
//
//  channel | ports  | direction | handshake
//  --------+--------+-----------+------------------------------
//  command | req_*  | in        | valid/ready, one beat per item
//  result  | rsp_*  | out       | valid/ready, one beat per item
//  config  | csr_*  | in        | write enable, no wait
//
// Tick and stop beats go from the accept straight to the execute state; a start
// beat first runs the 20 one-bit iterations of the restoring divider.
// One command at a time: req_ready is low from accept until the result is
// loaded into the output register. A stalled result holds the block in its
// update state; a new command is taken while a loaded result waits.
// Reset gives mode single-coil, base interval 293, all coils off.
module stepper_phase_sequencer (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  sps_pkg::opcode_type    req_opcode,
   input  sps_pkg::count_type     req_step_count,
   input  sps_pkg::speed_type     req_speed,
   input  logic                   req_clockwise,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output sps_pkg::coil_type      rsp_coils,
   output sps_pkg::count_type     rsp_steps_remaining,
   output logic                   rsp_busy_res,
   input  logic                   csr_we,
   input  sps_pkg::csr_index_type csr_index,
   input  sps_pkg::interval_type  csr_wdata
);
   import sps_pkg::*;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_DIV  = 2'd1;
   localparam logic [1:0] ST_EXEC = 2'd2;

   logic [1:0]        state_ff, state_in;
   mode_type          mode_ff;
   interval_type      base_ff;

   opcode_type        op_ff;
   count_type         cnt_ff;
   logic              cw_ff;

   logic [7:0]        dvsr_ff;
   logic [7:0]        rem_ff, rem_in;
   interval_type      quo_ff, quo_in;
   logic [DivCntW-1:0] div_cnt_ff, div_cnt_in;
   logic [8:0]        trial;
   logic              trial_ge;

   count_type         remaining_ff, remaining_in;
   interval_type      countdown_ff, countdown_in;
   interval_type      reload_ff, reload_in;
   phase_type         phase_ff, phase_in;
   logic              upward_ff, upward_in;
   coil_type          coil_ff, coil_in;

   logic              rsp_valid_ff;
   coil_type          rsp_coils_ff;
   count_type         rsp_remaining_ff;
   logic              rsp_busy_ff;

   logic              accept;
   logic              out_free;
   logic              commit;
   interval_type      cd_dec;
   interval_type      iv;
   phase_type         last;
   phase_type         ph_step;
   count_type         rem_dec;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign commit    = (state_ff == ST_EXEC) && out_free;

   // Restoring divider: one quotient bit per cycle.
   assign trial    = {rem_ff, quo_ff[DivSteps-1]};
   assign trial_ge = trial >= {1'b0, dvsr_ff};

   always_comb begin
      rem_in     = rem_ff;
      quo_in     = quo_ff;
      div_cnt_in = div_cnt_ff;
      if (state_ff == ST_DIV) begin
         rem_in     = trial_ge ? 8'(trial - {1'b0, dvsr_ff}) : trial[7:0];
         quo_in     = {quo_ff[DivSteps-2:0], trial_ge};
         div_cnt_in = div_cnt_ff + 1'b1;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = (req_opcode == OP_START) ? ST_DIV : ST_EXEC;
            end
         end
         ST_DIV: begin
            if (div_cnt_ff == DivCntW'(DivSteps - 1)) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign cd_dec  = countdown_ff - 1'b1;
   assign iv      = (quo_ff == '0) ? interval_type'(1) : quo_ff;
   assign last    = (mode_ff == MODE_HALF) ? 5'sd7 : 5'sd3;
   assign rem_dec = remaining_ff - 1'b1;

   always_comb begin
      if (upward_ff) begin
         ph_step = (phase_ff + 5'sd1 > last) ? 5'sd0 : phase_ff + 5'sd1;
      end else begin
         ph_step = (phase_ff - 5'sd1 < 5'sd0) ? last : phase_ff - 5'sd1;
      end
   end

   always_comb begin
      remaining_in = remaining_ff;
      countdown_in = countdown_ff;
      reload_in    = reload_ff;
      phase_in     = phase_ff;
      upward_in    = upward_ff;
      coil_in      = coil_ff;
      if (commit) begin
         case (op_ff)
            OP_TICK: begin
               if (mode_ff != MODE_OFF && remaining_ff != '0) begin
                  countdown_in = cd_dec;
                  if (cd_dec == '0) begin
                     countdown_in = reload_ff;
                     phase_in     = ph_step;
                     remaining_in = rem_dec;
                     coil_in      = (rem_dec == '0) ? coil_type'(0)
                                    : phase_pattern(mode_ff, ph_step, coil_ff);
                  end
               end
            end
            OP_START: begin
               reload_in    = iv;
               countdown_in = iv;
               upward_in    = !cw_ff;
               if (!cw_ff) begin
                  phase_in = -5'sd1;
               end else begin
                  phase_in = (mode_ff == MODE_HALF) ? 5'sd8 : 5'sd4;
               end
               coil_in      = '0;
               remaining_in = cnt_ff;
            end
            OP_STOP: remaining_in = '0;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         mode_ff      <= MODE_RESET;
         base_ff      <= INTERVAL_RESET;
         remaining_ff <= '0;
         countdown_ff <= '0;
         reload_ff    <= '0;
         phase_ff     <= '0;
         upward_ff    <= 1'b0;
         coil_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         div_cnt_ff   <= '0;
      end else begin
         state_ff     <= state_in;
         remaining_ff <= remaining_in;
         countdown_ff <= countdown_in;
         reload_ff    <= reload_in;
         phase_ff     <= phase_in;
         upward_ff    <= upward_in;
         coil_ff      <= coil_in;
         div_cnt_ff   <= accept ? '0 : div_cnt_in;
         if (csr_we) begin
            case (csr_index)
               CSR_STEP_MODE:     mode_ff <= csr_wdata[1:0];
               CSR_BASE_INTERVAL: base_ff <= csr_wdata;
               default: ;
            endcase
         end
         if (commit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Item latch, divider data path and result register.
   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff   <= req_opcode;
         cnt_ff  <= req_step_count;
         cw_ff   <= req_clockwise;
         dvsr_ff <= (req_speed == '0) ? 8'd1 : req_speed;
         rem_ff  <= '0;
         quo_ff  <= base_ff;
      end else begin
         rem_ff  <= rem_in;
         quo_ff  <= quo_in;
      end
      if (commit) begin
         rsp_coils_ff     <= coil_in;
         rsp_remaining_ff <= remaining_in;
         rsp_busy_ff      <= (remaining_in != '0);
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_coils           = rsp_coils_ff;
   assign rsp_steps_remaining = rsp_remaining_ff;
   assign rsp_busy_res        = rsp_busy_ff;

`include "assert_macros.svh"

   `SPS_ASSERT(a_busy_match, rsp_valid_ff |-> (rsp_busy_ff == (rsp_remaining_ff != '0)))
   `SPS_ASSERT(a_cd_live, (remaining_ff != '0) |-> (countdown_ff != '0))
   `SPS_ASSERT(a_div_bound, (state_ff == ST_DIV) |-> (dvsr_ff != '0))
   `SPS_NEVER(a_phase_range, (phase_ff < -5'sd1) || (phase_ff > 5'sd8))

endmodule
